[rtl/core/iff_pkg.sv]
// shared types, codes and character constants for the integer field formatter
`default_nettype none

package iff_pkg;

   localparam int MAX_FIELD_WIDTH  = 64;
   localparam int MAG_WIDTH        = 64;
   localparam int NUM_DIGITS       = 20;
   localparam int PTR_DIGITS       = 8;
   localparam int DIGIT_WIDTH      = 4;
   localparam int OP_WIDTH         = 3;
   localparam int FIELD_WIDTH_BITS = 7;
   localparam int COUNT_WIDTH      = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int ND_WIDTH         = $clog2(NUM_DIGITS + 1);

   // conversion codes
   localparam logic [OP_WIDTH-1:0] OP_SIGNED_DEC   = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_UNSIGNED_DEC = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_HEX_LOWER    = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_HEX_UPPER    = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_PTR_LOWER    = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_PTR_UPPER    = 3'd5;

   // ascii
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_CONVERT,
      CELL_SHIFT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         decimal;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_LEAD_PAD,
      ST_SIGN,
      ST_PREFIX_0,
      ST_PREFIX_X,
      ST_DIGIT,
      ST_TRAIL_PAD
   } state_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_WIDTH-1:0] d,
                                             input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < DIGIT_WIDTH'(10)) begin
         return CHAR_ZERO + 8'(d);
      end
      return base + 8'(d) - 8'd10;
   endfunction

endpackage

`default_nettype wire

[rtl/core/iff_cell.sv]
// one digit cell of the conversion chain: shift-and-add-3 step, digit shift
`default_nettype none

module iff_cell (
   input  logic                            clock,
   input  iff_pkg::cell_ctrl_type          cell_ctrl,
   input  logic                            lower_bit,
   input  logic [iff_pkg::DIGIT_WIDTH-1:0] lower_digit,
   output logic                            upper_bit,
   output logic [iff_pkg::DIGIT_WIDTH-1:0] digit
);
   import iff_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   // add 3 to digits of five and over before each shift in decimal mode
   assign adjusted  = (cell_ctrl.decimal && digit_ff >= DIGIT_WIDTH'(5)) ?
                      digit_ff + DIGIT_WIDTH'(3) : digit_ff;
   assign upper_bit = adjusted[DIGIT_WIDTH-1];
   assign digit     = digit_ff;

   always_comb begin
      case (cell_ctrl.cmd)
         CELL_CLEAR:   digit_in = '0;
         CELL_CONVERT: digit_in = {adjusted[DIGIT_WIDTH-2:0], lower_bit};
         CELL_SHIFT:   digit_in = lower_digit;
         default:      digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

`default_nettype wire

[rtl/core/iff_ctrl.sv]
// sequencer: operand capture, conversion and strip control, character emission
`default_nettype none

module iff_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [iff_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic [iff_pkg::MAG_WIDTH-1:0]        req_value,
   input  logic                                 req_wide,
   input  logic [iff_pkg::FIELD_WIDTH_BITS-1:0] req_field_width,
   input  logic                                 req_left_justify,
   input  logic                                 req_zero_pad,
   input  logic                                 req_force_plus,
   input  logic                                 req_alternate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_character,
   output logic                                 rsp_last,
   output iff_pkg::cell_ctrl_type               cell_ctrl,
   output logic                                 serial_bit,
   input  logic [iff_pkg::DIGIT_WIDTH-1:0]      top_digit
);
   import iff_pkg::*;

   state_type state_ff, state_in;

   logic [OP_WIDTH-1:0]    op_ff, op_in;
   logic                   lj_ff, lj_in;
   logic                   zp_ff, zp_in;
   logic                   alt_ff, alt_in;
   logic                   neg_ff, neg_in;
   logic                   sign_ff, sign_in;
   logic                   nz_ff, nz_in;
   logic [COUNT_WIDTH-1:0] fw_ff, fw_in;
   logic [MAG_WIDTH-1:0]   mag_ff, mag_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [ND_WIDTH-1:0]    nd_ff, nd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   out_free;
   logic                   is_ptr;
   logic                   is_upper;
   logic                   is_decimal;
   logic                   trail_pad;
   logic                   strip_go;
   logic [ND_WIDTH-1:0]    strip_limit;
   logic [COUNT_WIDTH-1:0] body_len;
   logic [COUNT_WIDTH-1:0] pad;
   logic                   emit_valid;
   logic [7:0]             emit_char;
   logic                   emit_last;

   // operand decode at capture
   logic [MAG_WIDTH-1:0]   v_masked;
   logic [MAG_WIDTH-1:0]   v_negated;
   logic                   v_signbit;
   logic                   v_nz;
   logic                   v_neg;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign serial_bit    = mag_ff[MAG_WIDTH-1];

   always_comb begin
      v_masked  = req_wide ? req_value : {{(MAG_WIDTH/2){1'b0}}, req_value[MAG_WIDTH/2-1:0]};
      v_negated = MAG_WIDTH'(0) - v_masked;
      if (!req_wide) begin
         v_negated[MAG_WIDTH-1:MAG_WIDTH/2] = '0;
      end
      v_signbit = req_wide ? req_value[MAG_WIDTH-1] : req_value[MAG_WIDTH/2-1];
      v_nz      = (v_masked != '0);
      v_neg     = (req_operation == OP_SIGNED_DEC) && v_signbit;
   end

   assign is_ptr      = (op_ff == OP_PTR_LOWER) || (op_ff == OP_PTR_UPPER);
   assign is_upper    = (op_ff == OP_HEX_UPPER) || (op_ff == OP_PTR_UPPER);
   assign is_decimal  = (op_ff == OP_SIGNED_DEC) || (op_ff == OP_UNSIGNED_DEC);
   assign trail_pad   = lj_ff && !is_ptr && (cnt_ff != '0);
   assign strip_limit = is_ptr ? ND_WIDTH'(PTR_DIGITS) : ND_WIDTH'(1);
   assign strip_go    = (top_digit == '0) && (nd_ff > strip_limit);
   assign body_len    = COUNT_WIDTH'(nd_ff) + COUNT_WIDTH'(sign_ff);
   assign pad         = (fw_ff > body_len) ? fw_ff - body_len : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation <= OP_PTR_UPPER) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (cnt_ff == '0) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (!strip_go) begin
               if (is_ptr) begin
                  state_in = (alt_ff && nz_ff) ? ST_PREFIX_0 : ST_DIGIT;
               end else if (!lj_ff && pad != '0) begin
                  state_in = ST_LEAD_PAD;
               end else if (sign_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_LEAD_PAD: begin
            if (out_free && cnt_ff == COUNT_WIDTH'(1)) begin
               state_in = sign_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_PREFIX_0: begin
            if (out_free) begin
               state_in = ST_PREFIX_X;
            end
         end
         ST_PREFIX_X: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free && nd_ff == ND_WIDTH'(1)) begin
               state_in = trail_pad ? ST_TRAIL_PAD : ST_IDLE;
            end
         end
         ST_TRAIL_PAD: begin
            if (out_free && cnt_ff == COUNT_WIDTH'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cell_ctrl.cmd     = CELL_HOLD;
      cell_ctrl.decimal = is_decimal;
      emit_valid        = 1'b0;
      emit_char         = CHAR_SPACE;
      emit_last         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cell_ctrl.cmd = CELL_CLEAR;
            end
         end
         ST_CONVERT: cell_ctrl.cmd = CELL_CONVERT;
         ST_STRIP: begin
            if (strip_go) begin
               cell_ctrl.cmd = CELL_SHIFT;
            end
         end
         ST_LEAD_PAD: begin
            emit_valid = 1'b1;
            emit_char  = zp_ff ? CHAR_ZERO : CHAR_SPACE;
         end
         ST_SIGN: begin
            emit_valid = 1'b1;
            emit_char  = neg_ff ? CHAR_MINUS : CHAR_PLUS;
         end
         ST_PREFIX_0: begin
            emit_valid = 1'b1;
            emit_char  = CHAR_ZERO;
         end
         ST_PREFIX_X: begin
            emit_valid = 1'b1;
            emit_char  = CHAR_X;
         end
         ST_DIGIT: begin
            emit_valid = 1'b1;
            emit_char  = digit_char(top_digit, is_upper);
            emit_last  = (nd_ff == ND_WIDTH'(1)) && !trail_pad;
            if (out_free) begin
               cell_ctrl.cmd = CELL_SHIFT;
            end
         end
         ST_TRAIL_PAD: begin
            emit_valid = 1'b1;
            emit_char  = CHAR_SPACE;
            emit_last  = (cnt_ff == COUNT_WIDTH'(1));
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in        = op_ff;
      lj_in        = lj_ff;
      zp_in        = zp_ff;
      alt_in       = alt_ff;
      neg_in       = neg_ff;
      sign_in      = sign_ff;
      nz_in        = nz_ff;
      fw_in        = fw_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      nd_in        = nd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         op_in   = req_operation;
         lj_in   = req_left_justify;
         zp_in   = req_zero_pad;
         alt_in  = req_alternate;
         neg_in  = v_neg;
         nz_in   = v_nz;
         sign_in = v_nz && (v_neg || req_force_plus) && (req_operation <= OP_HEX_UPPER);
         fw_in   = (req_field_width > FIELD_WIDTH_BITS'(MAX_FIELD_WIDTH)) ?
                   COUNT_WIDTH'(MAX_FIELD_WIDTH) : COUNT_WIDTH'(req_field_width);
         mag_in  = v_neg ? v_negated : v_masked;
         cnt_in  = COUNT_WIDTH'(MAG_WIDTH - 1);
      end

      case (state_ff)
         ST_CONVERT: begin
            mag_in = {mag_ff[MAG_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - COUNT_WIDTH'(1);
            nd_in  = ND_WIDTH'(NUM_DIGITS);
         end
         ST_STRIP: begin
            if (strip_go) begin
               nd_in = nd_ff - ND_WIDTH'(1);
            end else begin
               cnt_in = pad;
            end
         end
         ST_LEAD_PAD, ST_TRAIL_PAD: begin
            if (out_free) begin
               cnt_in = cnt_ff - COUNT_WIDTH'(1);
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               nd_in = nd_ff - ND_WIDTH'(1);
            end
         end
         default: ;
      endcase

      if (out_free) begin
         rsp_valid_in = emit_valid;
         if (emit_valid) begin
            rsp_char_in = emit_char;
            rsp_last_in = emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         nd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         nd_ff        <= nd_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lj_ff       <= lj_in;
      zp_ff       <= zp_in;
      alt_ff      <= alt_in;
      neg_ff      <= neg_in;
      sign_ff     <= sign_in;
      nz_ff       <= nz_in;
      fw_ff       <= fw_in;
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

[rtl/core/integer_field_formatter.sv]
// top level of the integer field formatter: sequencer plus chain of digit cells
//
// turns one integer and a printf-style conversion spec into the characters of
// the field, one rsp transaction per character, most significant first, with
// rsp_last on the final one. conversions: signed and unsigned decimal, lower
// and upper hex, and pointer (at least eight hex digits, "0x" prefix when
// req_alternate is set and the value is nonzero). outside pointers, zero prints
// a bare "0" with no sign; padding goes ahead of the sign, or after the body when
// left justified. operation codes six and seven are taken and produce nothing.
// one req transaction is handled at a time. after acceptance the magnitude is
// fed one bit per cycle into a row of twenty 4-bit digit cells (shift-and-add-3
// in decimal, plain shift in hex). leading zero digits are then shifted out of
// the top cell at one per cycle (up to 19, fewer for pointers), the last strip
// step decides the layout, and the characters leave at one per cycle while
// rsp_ready is high. stripped zeros plus digits always make twenty. the result
// register lets the last character of one item wait while the next item is
// accepted and converted
`default_nettype none

module integer_field_formatter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [iff_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic [iff_pkg::MAG_WIDTH-1:0]        req_value,
   input  logic                                 req_wide,
   input  logic [iff_pkg::FIELD_WIDTH_BITS-1:0] req_field_width,
   input  logic                                 req_left_justify,
   input  logic                                 req_zero_pad,
   input  logic                                 req_force_plus,
   input  logic                                 req_alternate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_character,
   output logic                                 rsp_last
);
   import iff_pkg::*;

   cell_ctrl_type          cell_ctrl;
   // carries run upward from the serial magnitude bit into cell 0
   logic                   chain_bit   [NUM_DIGITS+1];
   // digits move upward by one cell for each strip or emitted digit
   logic [DIGIT_WIDTH-1:0] chain_digit [NUM_DIGITS+1];

   assign chain_digit[0] = '0;

   iff_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_wide         (req_wide),
      .req_field_width  (req_field_width),
      .req_left_justify (req_left_justify),
      .req_zero_pad     (req_zero_pad),
      .req_force_plus   (req_force_plus),
      .req_alternate    (req_alternate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .cell_ctrl        (cell_ctrl),
      .serial_bit       (chain_bit[0]),
      .top_digit        (chain_digit[NUM_DIGITS])
   );

   // cell 0 holds the least significant digit, the top cell feeds the output
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      iff_cell u_cell (
         .clock       (clock),
         .cell_ctrl   (cell_ctrl),
         .lower_bit   (chain_bit[i]),
         .lower_digit (chain_digit[i]),
         .upper_bit   (chain_bit[i+1]),
         .digit       (chain_digit[i+1])
      );
   end

endmodule

`default_nettype wire

[rtl/core/iff_checker.sv]
// port-level assertions for the integer field formatter, bound to the top level
`default_nettype none

module iff_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [iff_pkg::OP_WIDTH-1:0] req_operation,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [7:0]                   rsp_character,
   input logic                         rsp_last
);
   import iff_pkg::*;

   // a stalled result holds its character and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   // out of reset the block is idle with nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // a valid conversion keeps the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation <= OP_PTR_UPPER) |=> !req_ready)
      else $error("req taken again during conversion");

   // only the final character of a field may still wait while a new req is taken
   a_ready_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req ready while a field is half emitted");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);

`default_nettype wire

[dv/tb_integer_field_formatter.sv]
// testbench for the integer field formatter: random and directed fields checked against a predictor
`timescale 1ns / 1ps

// one req transaction as seen on the ports
typedef struct {
   logic [iff_pkg::OP_WIDTH-1:0]         operation;
   logic [iff_pkg::MAG_WIDTH-1:0]        value;
   logic                                 wide;
   logic [iff_pkg::FIELD_WIDTH_BITS-1:0] field_width;
   logic                                 left_justify;
   logic                                 zero_pad;
   logic                                 force_plus;
   logic                                 alternate;
} fmt_request_type;

// one rsp transaction: a character and its end-of-field marker
typedef struct {
   logic [7:0] character;
   logic       last;
} fmt_char_type;

// works out the characters of each accepted field and checks them as they leave
class field_scoreboard;
   fmt_char_type expected_chars[$];
   int unsigned  mismatches;

   function new();
      mismatches = 0;
   endfunction

   // expected characters of one field, appended in output order
   function void format_field(fmt_request_type r);
      logic [63:0]  v;
      logic [63:0]  mag;
      logic [7:0]   d;
      logic [7:0]   alpha;
      logic [7:0]   digits[$];
      logic [7:0]   body[$];
      logic [7:0]   chars[$];
      logic         neg;
      logic         sign_bit;
      int unsigned  base;
      int           fw;
      int           pad;
      int           i;
      fmt_char_type c;

      // codes six and seven are taken but produce nothing
      if (r.operation > iff_pkg::OP_PTR_UPPER) begin
         return;
      end

      v = r.value;
      if (!r.wide) begin
         v[63:32] = '0;
      end
      mag = v;
      neg = 1'b0;
      if (r.operation == iff_pkg::OP_SIGNED_DEC && v != 0) begin
         sign_bit = r.wide ? v[63] : v[31];
         if (sign_bit) begin
            neg = 1'b1;
            mag = -v;
            if (!r.wide) begin
               mag[63:32] = '0;
            end
         end
      end

      base = (r.operation == iff_pkg::OP_SIGNED_DEC ||
              r.operation == iff_pkg::OP_UNSIGNED_DEC) ? 10 : 16;
      alpha = (r.operation == iff_pkg::OP_HEX_UPPER ||
               r.operation == iff_pkg::OP_PTR_UPPER) ? iff_pkg::CHAR_UPPER_A
                                                     : iff_pkg::CHAR_LOWER_A;
      if (mag == 0) begin
         digits.push_back(iff_pkg::CHAR_ZERO);
      end
      while (mag != 0) begin
         d = 8'(mag % base);
         digits.push_front(d < 8'd10 ? iff_pkg::CHAR_ZERO + d : alpha + d - 8'd10);
         mag = mag / base;
      end

      if (r.operation == iff_pkg::OP_PTR_LOWER || r.operation == iff_pkg::OP_PTR_UPPER) begin
         // width and the flags other than alternate do not apply to pointers
         if (r.alternate && v != 0) begin
            chars.push_back(iff_pkg::CHAR_ZERO);
            chars.push_back(iff_pkg::CHAR_X);
         end
         for (i = digits.size(); i < iff_pkg::PTR_DIGITS; i++) begin
            chars.push_back(iff_pkg::CHAR_ZERO);
         end
         chars = {chars, digits};
      end else begin
         if (v != 0) begin
            if (neg) begin
               body.push_back(iff_pkg::CHAR_MINUS);
            end else if (r.force_plus) begin
               body.push_back(iff_pkg::CHAR_PLUS);
            end
         end
         body = {body, digits};
         fw = r.field_width;
         if (fw > iff_pkg::MAX_FIELD_WIDTH) begin
            fw = iff_pkg::MAX_FIELD_WIDTH;
         end
         pad = (fw > body.size()) ? fw - body.size() : 0;
         if (!r.left_justify) begin
            for (i = 0; i < pad; i++) begin
               chars.push_back(r.zero_pad ? iff_pkg::CHAR_ZERO : iff_pkg::CHAR_SPACE);
            end
         end
         chars = {chars, body};
         if (r.left_justify) begin
            for (i = 0; i < pad; i++) begin
               chars.push_back(iff_pkg::CHAR_SPACE);
            end
         end
      end

      foreach (chars[k]) begin
         c.character = chars[k];
         c.last      = (k == chars.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   function void check_char(logic [7:0] character, logic last);
      fmt_char_type want;
      if (expected_chars.size() == 0) begin
         $error("rsp_character %h (last %b) arrived with nothing expected", character, last);
         mismatches++;
         return;
      end
      want = expected_chars.pop_front();
      if (character !== want.character) begin
         $error("rsp_character mismatch: expected %h, actual %h", want.character, character);
         mismatches++;
      end
      if (last !== want.last) begin
         $error("rsp_last mismatch: expected %b, actual %b", want.last, last);
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return expected_chars.size();
   endfunction
endclass

module tb_integer_field_formatter;
   import iff_pkg::*;

   // operation codes the block takes but ignores
   localparam logic [OP_WIDTH-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_RESERVED_B = 3'd7;

   localparam int RANDOM_ITEMS   = 238;
   localparam int STEADY_FIRST   = 100;   // idling switched off for items in this window
   localparam int STEADY_LAST    = 159;
   localparam int IDLE_PERCENT   = 19;
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either channel
   localparam int SETTLE_CYCLES  = 200;   // quiet time after the last expected character

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [OP_WIDTH-1:0]         req_operation;
   logic [MAG_WIDTH-1:0]        req_value;
   logic                        req_wide;
   logic [FIELD_WIDTH_BITS-1:0] req_field_width;
   logic                        req_left_justify;
   logic                        req_zero_pad;
   logic                        req_force_plus;
   logic                        req_alternate;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [7:0]                  rsp_character;
   logic                        rsp_last;

   field_scoreboard sb;
   bit              steady;        // no idling on either side while set
   int unsigned     quiet_cycles;  // consecutive cycles without any transaction

   integer_field_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_wide         (req_wide),
      .req_field_width  (req_field_width),
      .req_left_justify (req_left_justify),
      .req_zero_pad     (req_zero_pad),
      .req_force_plus   (req_force_plus),
      .req_alternate    (req_alternate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // receiver: ready changes on the falling edge only, stalls at random outside the steady window
   always @(negedge clock) begin
      rsp_ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // monitor: both channels sampled at the rising edge, before the block's registers move
   always @(posedge clock) begin
      fmt_request_type seen;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            seen.operation    = req_operation;
            seen.value        = req_value;
            seen.wide         = req_wide;
            seen.field_width  = req_field_width;
            seen.left_justify = req_left_justify;
            seen.zero_pad     = req_zero_pad;
            seen.force_plus   = req_force_plus;
            seen.alternate    = req_alternate;
            sb.format_field(seen);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_char(rsp_character, rsp_last);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // watchdog: a hung block ends the run
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic fmt_request_type make_request(logic [OP_WIDTH-1:0] op, logic [63:0] value,
                                                    logic wide, logic [6:0] fw, logic lj,
                                                    logic zp, logic plus, logic alt);
      fmt_request_type r;
      r.operation    = op;
      r.value        = value;
      r.wide         = wide;
      r.field_width  = fw;
      r.left_justify = lj;
      r.zero_pad     = zp;
      r.force_plus   = plus;
      r.alternate    = alt;
      return r;
   endfunction

   // random field: value drawn from a handful of shapes so signs, extremes and long digit runs all turn up
   function automatic fmt_request_type random_request();
      fmt_request_type r;
      logic [63:0]     v;
      case ($urandom_range(0, 6))
         0: v = 64'($urandom_range(0, 20));
         1: v = {$urandom, $urandom};
         2: v = -64'($urandom_range(1, 1000));
         3: v = {$urandom, 1'b1, 31'($urandom)};        // negative in the low word, junk above
         4: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         5: v = {32'($urandom), 32'($urandom_range(0, 99999))};
         default: begin
            case ($urandom_range(0, 5))
               0: v = 64'h8000_0000_0000_0000;
               1: v = 64'h7fff_ffff_ffff_ffff;
               2: v = '1;
               3: v = 64'h0000_0000_8000_0000;
               4: v = 64'h8ac7_2304_89e8_0000;   // ten to the nineteenth
               default: v = '0;
            endcase
         end
      endcase
      r.value = v;
      if ($urandom_range(0, 99) < 5) begin
         r.operation = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
      end else begin
         r.operation = OP_WIDTH'($urandom_range(OP_SIGNED_DEC, OP_PTR_UPPER));
      end
      // mostly narrow fields, now and then the widest and beyond
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.field_width = 7'($urandom_range(0, 10));
         4, 5, 6, 7: r.field_width = 7'($urandom_range(0, 30));
         default:    r.field_width = 7'($urandom_range(0, 127));
      endcase
      r.wide         = 1'($urandom);
      r.left_justify = 1'($urandom);
      r.zero_pad     = 1'($urandom);
      r.force_plus   = 1'($urandom);
      r.alternate    = 1'($urandom);
      return r;
   endfunction

   // sender: payload changes on the falling edge, valid held until the transaction is taken
   task automatic send_request(input fmt_request_type r);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation    = r.operation;
      req_value        = r.value;
      req_wide         = r.wide;
      req_field_width  = r.field_width;
      req_left_justify = r.left_justify;
      req_zero_pad     = r.zero_pad;
      req_force_plus   = r.force_plus;
      req_alternate    = r.alternate;
      req_valid        = 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // hold the sender back until every outstanding character has come out
   task automatic drain_fields();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      fmt_request_type r;
      int              sent;

      sb               = new();
      steady           = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_SIGNED_DEC;
      req_value        = '0;
      req_wide         = 1'b0;
      req_field_width  = '0;
      req_left_justify = 1'b0;
      req_zero_pad     = 1'b0;
      req_force_plus   = 1'b0;
      req_alternate    = 1'b0;
      rsp_ready        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed fields: zero, signs, extremes, every conversion, saturated width, pointers
      send_request(make_request(OP_SIGNED_DEC, 64'd0, 1, 7'd5, 0, 1, 1, 0));
      send_request(make_request(OP_SIGNED_DEC, 64'hffff_ffff, 0, 7'd6, 0, 1, 0, 0));
      send_request(make_request(OP_SIGNED_DEC, 64'h8000_0000_0000_0000, 1, 7'd0, 0, 0, 1, 0));
      send_request(make_request(OP_SIGNED_DEC, 64'h1234_5678_8000_0000, 0, 7'd14, 1, 0, 0, 1));
      send_request(make_request(OP_SIGNED_DEC, 64'h7fff_ffff_ffff_ffff, 1, 7'd25, 0, 0, 1, 0));
      send_request(make_request(OP_SIGNED_DEC, 64'd123, 1, 7'd10, 0, 1, 1, 0));
      send_request(make_request(OP_SIGNED_DEC, -64'd5, 1, 7'd1, 1, 1, 0, 0));
      send_request(make_request(OP_UNSIGNED_DEC, '1, 1, 7'd0, 0, 0, 0, 0));
      send_request(make_request(OP_UNSIGNED_DEC, '1, 0, 7'd20, 1, 0, 1, 0));
      send_request(make_request(OP_UNSIGNED_DEC, 64'h8ac7_2304_89e8_0000, 1, 7'd64, 0, 1, 0, 1));
      send_request(make_request(OP_HEX_LOWER, 64'hdead_beef_cafe_f00d, 1, 7'd0, 0, 0, 1, 1));
      send_request(make_request(OP_HEX_UPPER, 64'hdead_beef_cafe_f00d, 1, 7'd64, 0, 0, 0, 0));
      send_request(make_request(OP_HEX_UPPER, 64'h00ab_cdef, 0, 7'd127, 1, 1, 0, 0));
      send_request(make_request(OP_HEX_LOWER, 64'd0, 1, 7'd65, 0, 1, 1, 1));
      send_request(make_request(OP_PTR_LOWER, 64'd0, 1, 7'd30, 0, 0, 1, 1));
      send_request(make_request(OP_PTR_UPPER, 64'h1234, 1, 7'd40, 1, 1, 1, 1));
      send_request(make_request(OP_PTR_LOWER, '1, 1, 7'd0, 0, 0, 0, 1));
      send_request(make_request(OP_PTR_UPPER, 64'hffff_ffff_abcd_ef01, 0, 7'd3, 0, 0, 0, 0));
      send_request(make_request(OP_PTR_UPPER, 64'h0000_00fe_dcba_9876, 1, 7'd0, 0, 0, 0, 1));
      send_request(make_request(OP_RESERVED_A, 64'd42, 1, 7'd10, 0, 0, 0, 0));
      send_request(make_request(OP_RESERVED_B, '1, 0, 7'd64, 1, 1, 1, 1));
      send_request(make_request(OP_SIGNED_DEC, 64'd9, 0, 7'd64, 1, 0, 0, 0));

      // first pause: everything must come out before the random traffic starts
      drain_fields();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == STEADY_FIRST) begin
            drain_fields();
            steady = 1'b1;
         end
         if (sent == STEADY_LAST + 1) begin
            steady = 1'b0;
         end
         r = random_request();
         send_request(r);
         sent++;
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
